/* design/clcd_pkg.sv */
// Shared types, constants and the microcode program for the character LCD sequencer.
// Used by clcd_seq, clcd_dpath and char_lcd_nibble_sequencer; depends on nothing.
package clcd_pkg;

  // Field and register widths
  localparam int REG_W     = 16;
  localparam int REG_IDX_W = 3;
  localparam int NIB_W     = 4;
  localparam int BYTE_W    = 8;
  localparam int COL_W     = 6;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_ENABLE_PULSE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DATA_SETTLE    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COMMAND_SETTLE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_POWER_UP       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INIT_WAIT      = 3'd4;

  // Register reset values (microseconds)
  localparam logic [REG_W-1:0] RST_ENABLE_PULSE   = 16'd1;
  localparam logic [REG_W-1:0] RST_DATA_SETTLE    = 16'd200;
  localparam logic [REG_W-1:0] RST_COMMAND_SETTLE = 16'd4500;
  localparam logic [REG_W-1:0] RST_POWER_UP       = 16'd15000;
  localparam logic [REG_W-1:0] RST_INIT_WAIT      = 16'd4200;

  // Cursor command constants
  localparam logic [BYTE_W-1:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [BYTE_W-1:0] ROW2_OFFSET   = 8'h40;

  // Microcode store geometry
  localparam int UC_DEPTH = 13;
  localparam int PC_W     = $clog2(UC_DEPTH);
  localparam logic [PC_W-1:0] ADDR_BYTE = 4'd0;  // send-byte routine
  localparam logic [PC_W-1:0] ADDR_INIT = 4'd4;  // power-up routine

  // Init command bytes, walked by a loop counter
  localparam int NUM_INIT = 5;
  localparam int IDX_W    = $clog2(NUM_INIT);
  localparam logic [IDX_W-1:0] INIT_IDX_LAST = IDX_W'(NUM_INIT - 1);

  // Request kinds
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_COMMAND = 2'd1,
    KIND_CURSOR  = 2'd2,
    KIND_INIT    = 2'd3
  } kind_t;

  // Nibble source for one pin event
  typedef enum logic [1:0] {
    NIB_HIGH  = 2'd0,
    NIB_LOW   = 2'd1,
    NIB_CONST = 2'd2
  } nib_sel_t;

  // Hold time source for one pin event
  typedef enum logic [2:0] {
    HOLD_PULSE  = 3'd0,
    HOLD_SETTLE = 3'd1,  // data or command settle by RS
    HOLD_DATA   = 3'd2,
    HOLD_POWER  = 3'd3,
    HOLD_INIT   = 3'd4
  } hold_sel_t;

  // Sequencing operation at the end of a step
  typedef enum logic [1:0] {
    OP_NEXT      = 2'd0,  // fall through
    OP_LOAD_INIT = 2'd1,  // load first init byte, jump to send-byte
    OP_LOOP      = 2'd2   // next init byte and jump back, else finish
  } op_t;

  // One control word
  typedef struct packed {
    logic             enable;
    nib_sel_t         nib_sel;
    logic [NIB_W-1:0] nib_const;
    hold_sel_t        hold_sel;
    op_t              op;
  } ucode_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic              emit;
    logic              last;
    ucode_t            word;
    logic              load_init;
    logic [BYTE_W-1:0] init_byte;
  } seq_ctl_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] byte_value;
    logic [1:0]        row;
    logic [COL_W-1:0]  column;
  } request_t;

  typedef struct packed {
    logic             rs_level;
    logic             enable_level;
    logic [NIB_W-1:0] data_nibble;
    logic [REG_W-1:0] hold_us;
    logic             last;
  } pin_event_t;

  // Microcode program
  function automatic ucode_t ucode_word(input logic [PC_W-1:0] addr);
    ucode_t w;
    w = '{enable: 1'b0, nib_sel: NIB_CONST, nib_const: 4'h0,
          hold_sel: HOLD_PULSE, op: OP_NEXT};
    case (addr)
      // send-byte routine
      4'd0: w = '{1'b1, NIB_HIGH,  4'h0, HOLD_PULSE,  OP_NEXT};
      4'd1: w = '{1'b0, NIB_HIGH,  4'h0, HOLD_SETTLE, OP_NEXT};
      4'd2: w = '{1'b1, NIB_LOW,   4'h0, HOLD_PULSE,  OP_NEXT};
      4'd3: w = '{1'b0, NIB_LOW,   4'h0, HOLD_SETTLE, OP_LOOP};
      // power-up routine
      4'd4: w = '{1'b0, NIB_CONST, 4'h0, HOLD_POWER,  OP_NEXT};
      4'd5: w = '{1'b1, NIB_CONST, 4'h3, HOLD_PULSE,  OP_NEXT};
      4'd6: w = '{1'b0, NIB_CONST, 4'h3, HOLD_INIT,   OP_NEXT};
      4'd7: w = '{1'b1, NIB_CONST, 4'h3, HOLD_PULSE,  OP_NEXT};
      4'd8: w = '{1'b0, NIB_CONST, 4'h3, HOLD_DATA,   OP_NEXT};
      4'd9: w = '{1'b1, NIB_CONST, 4'h3, HOLD_PULSE,  OP_NEXT};
      4'd10: w = '{1'b0, NIB_CONST, 4'h3, HOLD_DATA,  OP_NEXT};
      4'd11: w = '{1'b1, NIB_CONST, 4'h2, HOLD_PULSE, OP_NEXT};
      4'd12: w = '{1'b0, NIB_CONST, 4'h2, HOLD_INIT,  OP_LOAD_INIT};
      default: w = '{1'b0, NIB_CONST, 4'h0, HOLD_PULSE, OP_LOOP};
    endcase
    return w;
  endfunction

  // Init command bytes
  function automatic logic [BYTE_W-1:0] init_byte(input logic [IDX_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    b = 8'h0E;
    case (idx)
      3'd0: b = 8'h28;
      3'd1: b = 8'h08;
      3'd2: b = 8'h01;
      3'd3: b = 8'h06;
      default: b = 8'h0E;
    endcase
    return b;
  endfunction

endpackage

/* design/clcd_seq.sv */
// Microcode sequencer: step counter, control store fetch, init byte loop.
// Depends on clcd_pkg.
module clcd_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  clcd_pkg::kind_t     kind,
  output logic                busy,
  output clcd_pkg::seq_ctl_t  ctl
);

  logic [clcd_pkg::PC_W-1:0]  pc;
  logic [clcd_pkg::IDX_W-1:0] idx;
  logic                       init_mode;
  logic                       more_init;
  clcd_pkg::ucode_t           word;

  // Fetch and decode the current step
  assign word      = clcd_pkg::ucode_word(pc);
  assign more_init = init_mode && (idx != clcd_pkg::INIT_IDX_LAST);

  always_comb begin
    ctl.emit      = busy;
    ctl.word      = word;
    ctl.last      = busy && (word.op == clcd_pkg::OP_LOOP) && !more_init;
    ctl.load_init = 1'b0;
    ctl.init_byte = clcd_pkg::init_byte('0);
    case (word.op)
      clcd_pkg::OP_LOAD_INIT: begin
        ctl.load_init = busy;
        ctl.init_byte = clcd_pkg::init_byte('0);
      end
      clcd_pkg::OP_LOOP: begin
        ctl.load_init = busy && more_init;
        ctl.init_byte = clcd_pkg::init_byte(idx + 1'b1);
      end
      default: ;
    endcase
  end

  // Step counter and loop counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= clcd_pkg::ADDR_BYTE;
      idx       <= '0;
      init_mode <= 1'b0;
    end else if (accept) begin
      busy      <= 1'b1;
      idx       <= '0;
      init_mode <= (kind == clcd_pkg::KIND_INIT);
      pc        <= (kind == clcd_pkg::KIND_INIT) ? clcd_pkg::ADDR_INIT : clcd_pkg::ADDR_BYTE;
    end else if (busy) begin
      case (word.op)
        clcd_pkg::OP_LOAD_INIT: begin
          pc  <= clcd_pkg::ADDR_BYTE;
          idx <= '0;
        end
        clcd_pkg::OP_LOOP: begin
          if (more_init) begin
            pc  <= clcd_pkg::ADDR_BYTE;
            idx <= idx + 1'b1;
          end else begin
            busy <= 1'b0;
          end
        end
        default: pc <= pc + 1'b1;
      endcase
    end
  end

  // Checks
  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> $past(ctl.last))
    else $error("sequencer went idle without a final step");
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pc < clcd_pkg::PC_W'(clcd_pkg::UC_DEPTH)))
    else $error("step counter beyond the control store");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= clcd_pkg::INIT_IDX_LAST)
    else $error("init byte counter overrun");
  a_byte_only: assert property (@(posedge clk) disable iff (rst)
    busy && !init_mode |-> (pc < clcd_pkg::ADDR_INIT))
    else $error("byte request entered the power-up routine");

endmodule

/* design/clcd_dpath.sv */
// Datapath: configuration registers, byte and RS latches, pin event output register.
// Depends on clcd_pkg.
module clcd_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [clcd_pkg::REG_IDX_W-1:0]    wr_index,
  input  logic [clcd_pkg::REG_W-1:0]        wr_data,
  input  logic                              accept,
  input  clcd_pkg::request_t                request,
  input  clcd_pkg::seq_ctl_t                ctl,
  output logic                              event_valid,
  output clcd_pkg::pin_event_t              event_item
);

  logic [clcd_pkg::REG_W-1:0]  enable_pulse_us;
  logic [clcd_pkg::REG_W-1:0]  data_settle_us;
  logic [clcd_pkg::REG_W-1:0]  command_settle_us;
  logic [clcd_pkg::REG_W-1:0]  power_up_us;
  logic [clcd_pkg::REG_W-1:0]  init_wait_us;
  logic [clcd_pkg::BYTE_W-1:0] byte_reg;
  logic                        rs_mode;
  logic [clcd_pkg::BYTE_W-1:0] cursor_cmd;
  logic [clcd_pkg::BYTE_W-1:0] col_m1;
  logic [clcd_pkg::NIB_W-1:0]  nib;
  logic [clcd_pkg::REG_W-1:0]  hold;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_pulse_us   <= clcd_pkg::RST_ENABLE_PULSE;
      data_settle_us    <= clcd_pkg::RST_DATA_SETTLE;
      command_settle_us <= clcd_pkg::RST_COMMAND_SETTLE;
      power_up_us       <= clcd_pkg::RST_POWER_UP;
      init_wait_us      <= clcd_pkg::RST_INIT_WAIT;
    end else if (wr_en) begin
      case (wr_index)
        clcd_pkg::REG_ENABLE_PULSE:   enable_pulse_us   <= wr_data;
        clcd_pkg::REG_DATA_SETTLE:    data_settle_us    <= wr_data;
        clcd_pkg::REG_COMMAND_SETTLE: command_settle_us <= wr_data;
        clcd_pkg::REG_POWER_UP:       power_up_us       <= wr_data;
        clcd_pkg::REG_INIT_WAIT:      init_wait_us      <= wr_data;
        default: ;
      endcase
    end
  end

  // Cursor address command, wraps modulo 256
  assign col_m1 = clcd_pkg::BYTE_W'(request.column) - 8'd1;
  always_comb begin
    case (request.row)
      2'd1:    cursor_cmd = clcd_pkg::CMD_SET_DDRAM + col_m1;
      2'd2:    cursor_cmd = clcd_pkg::CMD_SET_DDRAM + clcd_pkg::ROW2_OFFSET + col_m1;
      default: cursor_cmd = clcd_pkg::CMD_SET_DDRAM;
    endcase
  end

  // Byte to send and register select mode
  always_ff @(posedge clk) begin
    if (accept) begin
      rs_mode  <= (request.kind == clcd_pkg::KIND_DATA);
      byte_reg <= (request.kind == clcd_pkg::KIND_CURSOR) ? cursor_cmd : request.byte_value;
    end else if (ctl.load_init) begin
      byte_reg <= ctl.init_byte;
    end
  end

  // Nibble and hold time of the current step
  always_comb begin
    case (ctl.word.nib_sel)
      clcd_pkg::NIB_HIGH: nib = byte_reg[7:4];
      clcd_pkg::NIB_LOW:  nib = byte_reg[3:0];
      default:            nib = ctl.word.nib_const;
    endcase
    case (ctl.word.hold_sel)
      clcd_pkg::HOLD_PULSE:  hold = enable_pulse_us;
      clcd_pkg::HOLD_SETTLE: hold = rs_mode ? data_settle_us : command_settle_us;
      clcd_pkg::HOLD_DATA:   hold = data_settle_us;
      clcd_pkg::HOLD_POWER:  hold = power_up_us;
      clcd_pkg::HOLD_INIT:   hold = init_wait_us;
      default:               hold = enable_pulse_us;
    endcase
  end

  // Output register, one item per emitted step
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else begin
      event_valid <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      event_item.rs_level     <= rs_mode;
      event_item.enable_level <= ctl.word.enable;
      event_item.data_nibble  <= nib;
      event_item.hold_us      <= hold;
      event_item.last         <= ctl.last;
    end
  end

endmodule

/* design/char_lcd_nibble_sequencer.sv */
// Top level of the character LCD 4-bit bus sequencer.
// Depends on clcd_pkg, clcd_seq and clcd_dpath.
//
// Use: drive request and pulse start while busy is low; the request is taken
// at that edge. Kinds: data character, command byte, cursor move, initialise.
// Each request becomes a train of pin events on event_item, each shown for
// one cycle with event_valid high; event_item.last marks the final one.
// The receiver cannot hold events off and must take one per valid cycle.
// Events leave through a register: the start edge loads the sequencer's
// step counter, and each step's event then passes the output register,
// one event per cycle. A byte request gives 4 events; an initialise
// request gives 29 events. busy drops as the last event is registered, so
// the next request can be taken at the edge that ends that event's cycle.
// The rate is set by the one-step-per-cycle microcode program counter.
// Timing registers are written through wr_en, wr_index and wr_data; the
// user must write them only while idle, the block itself does not enforce
// it. Indexes beyond the list are ignored. Synchronous reset clears the
// sequencer and output valid and restores the register defaults.
module char_lcd_nibble_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  clcd_pkg::request_t             request,
  output logic                           busy,
  input  logic                           wr_en,
  input  logic [clcd_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [clcd_pkg::REG_W-1:0]     wr_data,
  output logic                           event_valid,
  output clcd_pkg::pin_event_t           event_item
);

  logic               accept;
  clcd_pkg::seq_ctl_t ctl;

  assign accept = start && !busy;

  // Program sequencer
  clcd_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .kind   (request.kind),
    .busy   (busy),
    .ctl    (ctl)
  );

  // Datapath and output register
  clcd_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .accept      (accept),
    .request     (request),
    .ctl         (ctl),
    .event_valid (event_valid),
    .event_item  (event_item)
  );

endmodule
